>>> rtl/core/cbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  // address split of the cpu space
  localparam int PAGE_BITS        = 14;
  localparam int SYSTEM_RAM_BYTES = 8192;
  localparam int CART_RAM_BYTES   = 32768;
  localparam int OFFSET_W         = 22;
  localparam int ADDR_W           = 16;

  // fixed boot area and system ram window
  localparam logic [ADDR_W-1:0] FIXED_LIMIT = 16'h0400;
  localparam logic [ADDR_W-1:0] SRAM_MASK   = ADDR_W'(SYSTEM_RAM_BYTES - 1);

  // memory control value applied at reset
  localparam logic [7:0] MEM_CTRL_INIT = 8'hE7;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_EXPANSION_TYPE = 3'd0,
    CFG_CART_TYPE      = 3'd1,
    CFG_CARD_TYPE      = 3'd2,
    CFG_BIOS_TYPE      = 3'd3,
    CFG_EXPANSION_MASK = 3'd4,
    CFG_CART_MASK      = 3'd5,
    CFG_CARD_MASK      = 3'd6,
    CFG_BIOS_MASK      = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    CMD_READ      = 2'd0,
    CMD_MEM_CTRL  = 2'd1,
    CMD_BANK      = 2'd2,
    CMD_CRAM_CTRL = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    SLOT_EXPANSION = 2'd0,
    SLOT_CART      = 2'd1,
    SLOT_CARD      = 2'd2,
    SLOT_BIOS      = 2'd3
  } slot_t;

  typedef enum logic [1:0] {
    STYPE_ABSENT = 2'd0,
    STYPE_FLAT   = 2'd1,
    STYPE_PAGED  = 2'd2,
    STYPE_SINGLE = 2'd3
  } slot_type_t;

  typedef enum logic [1:0] {
    MODE_FLAT   = 2'd0,
    MODE_PAGED  = 2'd1,
    MODE_SINGLE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    TGT_DONE = 3'd0,
    TGT_OPEN = 3'd1,
    TGT_ROM  = 3'd2,
    TGT_CRAM = 3'd3,
    TGT_SRAM = 3'd4
  } target_t;

  // one translated result
  typedef struct packed {
    logic [2:0]          target;
    logic [1:0]          slot;
    logic [OFFSET_W-1:0] offset;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/cbm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] address;
  logic [1:0]  bank_select;
  logic [7:0]  write_value;

  modport source (output valid, command, address, bank_select, write_value, input ready);
  modport sink   (input valid, command, address, bank_select, write_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cbm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [1:0]  slot;
  logic [21:0] offset;

  modport source (output valid, target, slot, offset, input ready);
  modport sink   (input valid, target, slot, offset, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cartridge_bank_mapper_top.sv
// Bank mapper for a four-slot 8-bit console memory map.
// req channel: one request per command (cpu read, memory control write,
//   bank register write, cart ram control write). rsp channel: one result
//   per request giving target memory, active slot and byte offset.
// Configuration: cfg_write_enable, cfg_index and cfg_data write the slot
//   types and bank masks; writes are registered, no read-back.
// Each result is registered, into the result register or behind it in the skid entry.
// Throughput: one request per cycle while the skid entry is empty;
//   translation is a single level of muxing and masking between the
//   request handshake and the result register.
// A result register plus one skid entry sit on rsp, so a request is still
//   taken while one result waits; req.ready drops only once both are full
//   and rises again as soon as the receiver takes a result.
// Reset (rst, synchronous) applies a memory control write of 0xE7:
//   bios slot active, flat mode, bank registers 0, 1, 2, cart ram off,
//   all slot types absent and masks zero.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper_top
  import cbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_enable,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  cbm_req_if.sink         req,
  cbm_rsp_if.source       rsp
);

  // configuration registers
  logic [3:0][1:0] slot_type;
  logic [3:0][7:0] slot_mask;

  // mapper state
  logic [1:0]      active_slot;
  logic [1:0]      mapper_mode;
  logic [2:0][7:0] bank_regs;
  logic            cram_enable;
  logic            cram_page;

  logic [1:0]      active_slot_next;
  logic [1:0]      mapper_mode_next;
  logic [2:0][7:0] bank_regs_next;
  logic            cram_enable_next;
  logic            cram_page_next;

  // output register and skid entry
  logic out_valid;
  rsp_t out_data;
  logic skid_valid;
  rsp_t skid_data;

  logic req_fire;
  logic rsp_fire;
  rsp_t rsp_next;

  // translation intermediates
  logic [1:0]  window;
  logic [7:0]  cur_mask;
  logic [7:0]  win_bank;
  logic [21:0] paged_offset;
  logic [21:0] single_offset;

  assign req.ready = !skid_valid;
  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = out_valid && rsp.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_type <= '0;
      slot_mask <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_EXPANSION_TYPE: slot_type[SLOT_EXPANSION] <= cfg_data[1:0];
        CFG_CART_TYPE:      slot_type[SLOT_CART]      <= cfg_data[1:0];
        CFG_CARD_TYPE:      slot_type[SLOT_CARD]      <= cfg_data[1:0];
        CFG_BIOS_TYPE:      slot_type[SLOT_BIOS]      <= cfg_data[1:0];
        CFG_EXPANSION_MASK: slot_mask[SLOT_EXPANSION] <= cfg_data;
        CFG_CART_MASK:      slot_mask[SLOT_CART]      <= cfg_data;
        CFG_CARD_MASK:      slot_mask[SLOT_CARD]      <= cfg_data;
        CFG_BIOS_MASK:      slot_mask[SLOT_BIOS]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // state update for write commands
  always_comb begin
    active_slot_next = active_slot;
    mapper_mode_next = mapper_mode;
    bank_regs_next   = bank_regs;
    cram_enable_next = cram_enable;
    cram_page_next   = cram_page;
    if (req_fire) begin
      case (req.command)
        CMD_MEM_CTRL: begin
          // first clear disable bit wins: expansion, cart, card, bios
          if (!req.write_value[7]) begin
            active_slot_next = SLOT_EXPANSION;
            mapper_mode_next = MODE_FLAT;
          end else if (!req.write_value[6]) begin
            active_slot_next = SLOT_CART;
          end else if (!req.write_value[5]) begin
            active_slot_next = SLOT_CARD;
            mapper_mode_next = MODE_FLAT;
          end else if (!req.write_value[3]) begin
            active_slot_next = SLOT_BIOS;
            case (slot_type[SLOT_BIOS])
              STYPE_PAGED: begin
                mapper_mode_next = MODE_PAGED;
                bank_regs_next   = {8'd2, 8'd1, 8'd0};
              end
              STYPE_SINGLE: begin
                mapper_mode_next = MODE_SINGLE;
                bank_regs_next   = {8'd0, 8'd1, 8'd0};
              end
              default: mapper_mode_next = MODE_FLAT;
            endcase
          end
        end
        CMD_BANK: begin
          // bank select of 3 is dropped
          case (req.bank_select)
            2'd0:    bank_regs_next[0] = req.write_value;
            2'd1:    bank_regs_next[1] = req.write_value;
            2'd2:    bank_regs_next[2] = req.write_value;
            default: ;
          endcase
        end
        CMD_CRAM_CTRL: begin
          cram_enable_next = req.write_value[3];
          cram_page_next   = req.write_value[2];
        end
        default: ;
      endcase
    end
  end

  // read translation
  always_comb begin
    window   = req.address[15:14];
    cur_mask = slot_mask[active_slot];
    case (window)
      2'd0:    win_bank = bank_regs[0];
      2'd1:    win_bank = bank_regs[1];
      default: win_bank = bank_regs[2];
    endcase
    paged_offset  = {win_bank & cur_mask, req.address[PAGE_BITS-1:0]};
    single_offset = {bank_regs[2] & cur_mask, req.address[PAGE_BITS-1:0]};

    rsp_next.target = TGT_DONE;
    rsp_next.slot   = active_slot_next;
    rsp_next.offset = '0;
    if (req.command == CMD_READ) begin
      if (window == 2'd3) begin
        rsp_next.target = TGT_SRAM;
        rsp_next.offset = OFFSET_W'(req.address & SRAM_MASK);
      end else if (slot_type[active_slot] == STYPE_ABSENT) begin
        rsp_next.target = TGT_OPEN;
      end else if (req.address < FIXED_LIMIT) begin
        rsp_next.target = TGT_ROM;
        rsp_next.offset = OFFSET_W'(req.address[9:0]);
      end else begin
        rsp_next.target = TGT_ROM;
        rsp_next.offset = OFFSET_W'(req.address);
        case (mapper_mode)
          MODE_PAGED: begin
            if (window == 2'd2 && cram_enable) begin
              rsp_next.target = TGT_CRAM;
              rsp_next.offset = OFFSET_W'({cram_page, req.address[PAGE_BITS-1:0]});
            end else begin
              rsp_next.offset = paged_offset;
            end
          end
          MODE_SINGLE: begin
            if (window == 2'd2) begin
              rsp_next.offset = single_offset;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // mapper state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slot <= SLOT_BIOS;
      mapper_mode <= MODE_FLAT;
      bank_regs   <= {8'd2, 8'd1, 8'd0};
      cram_enable <= 1'b0;
      cram_page   <= 1'b0;
    end else begin
      active_slot <= active_slot_next;
      mapper_mode <= mapper_mode_next;
      bank_regs   <= bank_regs_next;
      cram_enable <= cram_enable_next;
      cram_page   <= cram_page_next;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= req_fire;
      end
    end else if (req_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_fire || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (req_fire) begin
        out_data <= rsp_next;
      end
    end else if (req_fire) begin
      skid_data <= rsp_next;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.target = out_data.target;
  assign rsp.slot   = out_data.slot;
  assign rsp.offset = out_data.offset;

  // skid entry only fills behind a waiting result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry holds a result while output register is empty");

  // expansion select forces flat mode
  assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.command == CMD_MEM_CTRL && !req.write_value[7])
      |=> (active_slot == SLOT_EXPANSION && mapper_mode == MODE_FLAT))
    else $error("expansion select did not force flat mode");

  // out-of-range bank select leaves bank registers alone
  assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.command == CMD_BANK && req.bank_select == 2'd3) |=> $stable(bank_regs))
    else $error("bank select 3 changed a bank register");

  // reset lands in the bios flat state
  assert property (@(posedge clk)
    $past(rst) |-> (active_slot == SLOT_BIOS && mapper_mode == MODE_FLAT && !out_valid))
    else $error("reset state is not bios flat with empty output");

endmodule

`default_nettype wire

>>> verif/cartridge_bank_mapper_top_tb.sv
`timescale 1ns / 1ps

module cartridge_bank_mapper_top_tb;
  import cbm_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS   = 40;
  localparam int BANK_COUNT   = 3;
  localparam int RANDOM_RUNS  = 96;

  localparam logic [1:0] SRAM_WINDOW = 2'd3;
  localparam logic [1:0] CRAM_WINDOW = 2'd2;

  logic       clk;
  logic       rst;
  logic       cfg_write_enable;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  cbm_req_if req_ch ();
  cbm_rsp_if rsp_ch ();

  cartridge_bank_mapper_top dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req              (req_ch),
    .rsp              (rsp_ch)
  );

  // mapper state mirrored by the testbench
  slot_type_t slot_types [4];
  logic [7:0] slot_masks [4];
  slot_t      cur_slot;
  mode_t      cur_mode;
  logic [7:0] bank_regs [BANK_COUNT];
  logic [7:0] cram_ctrl;

  rsp_t pending_translations [$];
  int   error_count   = 0;
  int   stall_cycles  = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // memory control write: first clear disable bit picks the slot
  function automatic void apply_memory_control(logic [7:0] value);
    if (!value[7]) begin
      cur_slot = SLOT_EXPANSION;
      cur_mode = MODE_FLAT;
    end else if (!value[6]) begin
      cur_slot = SLOT_CART;
    end else if (!value[5]) begin
      cur_slot = SLOT_CARD;
      cur_mode = MODE_FLAT;
    end else if (!value[3]) begin
      cur_slot = SLOT_BIOS;
      case (slot_types[SLOT_BIOS])
        STYPE_PAGED: begin
          cur_mode     = MODE_PAGED;
          bank_regs[0] = 8'd0;
          bank_regs[1] = 8'd1;
          bank_regs[2] = 8'd2;
        end
        STYPE_SINGLE: begin
          cur_mode     = MODE_SINGLE;
          bank_regs[0] = 8'd0;
          bank_regs[1] = 8'd1;
          bank_regs[2] = 8'd0;
        end
        default: cur_mode = MODE_FLAT;
      endcase
    end
  endfunction

  // applies one request to the mirrored state and returns its translation
  function automatic rsp_t translate_request(command_t cmd, logic [15:0] addr,
                                             logic [1:0] sel, logic [7:0] value);
    rsp_t        r;
    logic [1:0]  win;
    logic [13:0] page_off;
    logic [7:0]  bank;
    r.target = TGT_DONE;
    r.offset = '0;
    win      = addr[15:14];
    page_off = addr[13:0];
    case (cmd)
      CMD_READ: begin
        if (win == SRAM_WINDOW) begin
          r.target = TGT_SRAM;
          r.offset = OFFSET_W'(addr & SRAM_MASK);
        end else if (slot_types[cur_slot] == STYPE_ABSENT) begin
          r.target = TGT_OPEN;
        end else if (addr < FIXED_LIMIT) begin
          r.target = TGT_ROM;
          r.offset = OFFSET_W'(addr[9:0]);
        end else if (cur_mode == MODE_PAGED && win == CRAM_WINDOW && cram_ctrl[3]) begin
          r.target = TGT_CRAM;
          r.offset = OFFSET_W'({cram_ctrl[2], page_off});
        end else begin
          // flat keeps the window number as the page
          r.target = TGT_ROM;
          bank     = {6'd0, win};
          if (cur_mode == MODE_PAGED || (cur_mode == MODE_SINGLE && win == CRAM_WINDOW))
            bank = bank_regs[win] & slot_masks[cur_slot];
          r.offset = {bank, page_off};
        end
      end
      CMD_MEM_CTRL: apply_memory_control(value);
      CMD_BANK: begin
        if (sel < BANK_COUNT) bank_regs[sel] = value;
      end
      default: cram_ctrl = value;
    endcase
    r.slot = cur_slot;
    return r;
  endfunction

  // model update, result checking and prediction at each edge
  always @(posedge clk) begin
    rsp_t seen;
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        slot_types[i] = STYPE_ABSENT;
        slot_masks[i] = 8'h00;
      end
      cur_slot     = SLOT_BIOS;
      cur_mode     = MODE_FLAT;
      bank_regs[0] = 8'd0;
      bank_regs[1] = 8'd1;
      bank_regs[2] = 8'd2;
      cram_ctrl    = 8'h00;
      apply_memory_control(MEM_CTRL_INIT);
      pending_translations.delete();
    end else begin
      if (cfg_write_enable) begin
        if (cfg_index < CFG_EXPANSION_MASK) slot_types[cfg_index[1:0]] = slot_type_t'(cfg_data[1:0]);
        else slot_masks[cfg_index[1:0]] = cfg_data;
      end
      // a result is checked before this edge's request is predicted
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.target = rsp_ch.target;
        seen.slot   = rsp_ch.slot;
        seen.offset = rsp_ch.offset;
        if (pending_translations.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding (target %0d)",
                                    seen.target));
        end else begin
          want = pending_translations.pop_front();
          if (seen.target !== want.target)
            report_mismatch($sformatf("target %0d, expected %0d", seen.target, want.target));
          if (seen.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", seen.slot, want.slot));
          if (seen.offset !== want.offset)
            report_mismatch($sformatf("offset 0x%06h, expected 0x%06h",
                                      seen.offset, want.offset));
        end
      end
      if (req_ch.valid && req_ch.ready)
        pending_translations.push_back(translate_request(command_t'(req_ch.command),
                                                         req_ch.address, req_ch.bank_select,
                                                         req_ch.write_value));
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request, with random sender gaps ahead of it
  task automatic send_request(command_t cmd, logic [15:0] addr, logic [1:0] sel,
                              logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.address     <= addr;
    req_ch.bank_select <= sel;
    req_ch.write_value <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all eight registers; masks packed bios, card, cart, expansion
  task automatic load_config(slot_type_t exp_type, slot_type_t cart_type,
                             slot_type_t card_type, slot_type_t bios_type,
                             logic [31:0] masks);
    logic [7:0] values [8];
    values[CFG_EXPANSION_TYPE] = {6'd0, exp_type};
    values[CFG_CART_TYPE]      = {6'd0, cart_type};
    values[CFG_CARD_TYPE]      = {6'd0, card_type};
    values[CFG_BIOS_TYPE]      = {6'd0, bios_type};
    values[CFG_EXPANSION_MASK] = masks[7:0];
    values[CFG_CART_MASK]      = masks[15:8];
    values[CFG_CARD_MASK]      = masks[23:16];
    values[CFG_BIOS_MASK]      = masks[31:24];
    for (int i = 0; i < 8; i++) begin
      cfg_write_enable <= 1'b1;
      cfg_index        <= cfg_index_t'(i);
      cfg_data         <= values[i];
      @(posedge clk);
    end
    cfg_write_enable <= 1'b0;
  endtask

  // reset state: every slot absent, bios active
  task automatic test_open_bus();
    send_request(CMD_READ, 16'h0000, 2'd0, 8'h00);
    send_request(CMD_READ, 16'hC000, 2'd0, 8'h00);
    send_request(CMD_READ, 16'hFFFF, 2'd3, 8'hFF);
    wait_idle();
  endtask

  // each disable bit in priority order, then no bit clear
  task automatic test_slot_select();
    load_config(STYPE_FLAT, STYPE_SINGLE, STYPE_ABSENT, STYPE_PAGED, 32'h07_00_0F_FF);
    send_request(CMD_MEM_CTRL, 16'h0000, 2'd0, 8'h7F);
    send_request(CMD_READ, 16'h4000, 2'd0, 8'h00);
    send_request(CMD_MEM_CTRL, 16'h0000, 2'd0, 8'hBF);
    send_request(CMD_READ, 16'h8123, 2'd0, 8'h00);
    send_request(CMD_MEM_CTRL, 16'h0000, 2'd0, 8'hDF);
    send_request(CMD_READ, 16'h0000, 2'd0, 8'h00);
    send_request(CMD_MEM_CTRL, 16'h0000, 2'd0, 8'hF7);
    send_request(CMD_READ, 16'h8000, 2'd0, 8'h00);
    send_request(CMD_MEM_CTRL, 16'h0000, 2'd0, 8'hFF);
    wait_idle();
  endtask

  // bank registers, the ignored fourth select, cart ram overlay, single bank
  task automatic test_paged_windows();
    send_request(CMD_BANK, 16'h0000, 2'd0, 8'hFF);
    send_request(CMD_BANK, 16'h0000, 2'd1, 8'h80);
    send_request(CMD_BANK, 16'h0000, 2'd2, 8'h05);
    send_request(CMD_BANK, 16'h0000, 2'd3, 8'hAA);
    send_request(CMD_READ, 16'h4000, 2'd0, 8'h00);
    send_request(CMD_READ, 16'hBFFF, 2'd0, 8'h00);
    send_request(CMD_CRAM_CTRL, 16'h0000, 2'd0, 8'h0C);
    send_request(CMD_READ, 16'hBFFF, 2'd0, 8'h00);
    send_request(CMD_CRAM_CTRL, 16'h0000, 2'd0, 8'h00);
    wait_idle();
    load_config(STYPE_FLAT, STYPE_SINGLE, STYPE_ABSENT, STYPE_SINGLE, 32'hFF_00_0F_FF);
    send_request(CMD_MEM_CTRL, 16'h0000, 2'd0, 8'hF7);
    send_request(CMD_READ, 16'h8000, 2'd0, 8'h00);
    wait_idle();
  endtask

  // random request, biased towards slot selects and window edges
  task automatic send_random_request();
    command_t    cmd;
    logic [15:0] addr;
    logic [7:0]  value;
    int          pick;
    addr  = 16'($urandom);
    value = 8'($urandom);
    pick  = $urandom_range(99);
    if (pick < 50) begin
      cmd = CMD_READ;
      case ($urandom_range(3))
        0: addr[15:10] = '0;
        1: addr[13:0] = $urandom_range(1) ? 14'h0000 : 14'h3FFF;
        default: ;
      endcase
    end else if (pick < 65) begin
      cmd = CMD_MEM_CTRL;
      case ($urandom_range(6))
        0: value[7] = 1'b0;
        1: value[7:6] = 2'b10;
        2: value[7:5] = 3'b110;
        3, 4: begin
          value[7:5] = 3'b111;
          value[3]   = 1'b0;
        end
        5: value = value | 8'hE8;
        default: ;
      endcase
    end else if (pick < 85) begin
      cmd = CMD_BANK;
    end else begin
      cmd = CMD_CRAM_CTRL;
    end
    send_request(cmd, addr, 2'($urandom), value);
  endtask

  function automatic logic [7:0] random_mask();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // three idling phases, four register settings in each
  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 24 : 0;
      for (int setting = 0; setting < 4; setting++) begin
        wait_idle();
        if (setting == 0 && phase == 0)
          load_config(STYPE_ABSENT, STYPE_ABSENT, STYPE_ABSENT, STYPE_ABSENT, 32'h0);
        else if (setting == 0 && phase == 1)
          load_config(STYPE_PAGED, STYPE_PAGED, STYPE_PAGED, STYPE_PAGED, 32'hFFFF_FFFF);
        else if (setting == 0)
          load_config(STYPE_SINGLE, STYPE_SINGLE, STYPE_SINGLE, STYPE_SINGLE, 32'hFFFF_FFFF);
        else
          load_config(slot_type_t'($urandom_range(3)), slot_type_t'($urandom_range(3)),
                      slot_type_t'($urandom_range(3)), slot_type_t'($urandom_range(3)),
                      {random_mask(), random_mask(), random_mask(), random_mask()});
        repeat (RANDOM_RUNS) send_random_request();
      end
    end
  endtask

  // test sequence
  initial begin
    rst                <= 1'b1;
    cfg_write_enable   <= 1'b0;
    cfg_index          <= CFG_EXPANSION_TYPE;
    cfg_data           <= 8'h00;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= CMD_READ;
    req_ch.address     <= 16'h0000;
    req_ch.bank_select <= 2'd0;
    req_ch.write_value <= 8'h00;
    send_idle_pct = 24;
    recv_idle_pct = 66;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_open_bus();
    test_slot_select();
    test_paged_windows();
    test_random_traffic();
    wait_idle();

    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
